>>> hdl/finite_context_model_entropy_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the finite-context model entropy block.
// Shared forms for the concurrent checks of the RTL.
// ---------------------------------------------------------------------------
`ifndef FINITE_CONTEXT_MODEL_ENTROPY_TOP_MACROS_SVH
`define FINITE_CONTEXT_MODEL_ENTROPY_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk and quiet during rst.
`define FCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk and quiet during rst.
`define FCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/fcm_pkg.sv
// ---------------------------------------------------------------------------
// fcm_pkg
// Shared constants, register indexes and state types of the context model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcm_pkg;

  localparam int SYM_BITS       = 5;
  localparam int ORDER_DEF      = 2;
  localparam int ALPHABET_DEF   = 27;
  localparam int COUNT_BITS_DEF = 16;

  localparam int FRAC_BITS  = 10;
  localparam int ALPHA_FRAC = 12;
  localparam int ALPHA_W    = 16;
  localparam int INFO_W     = 16;
  localparam int SUM_W      = 40;
  localparam int SCORE_W    = 32;
  localparam int MANT_W     = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 1'b1;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd4096;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOG,
    ST_FIN
  } fcm_state_t;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQR
  } lg_state_t;

endpackage

>>> hdl/fcm_ram.sv
// ---------------------------------------------------------------------------
// fcm_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/fcm_log2.sv
// ---------------------------------------------------------------------------
// fcm_log2
// Iterative fixed-point log2: leading-one search one bit per cycle, then
// ten squaring steps that each yield one fraction bit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcm_log2 #(
  parameter int XW = 34
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [XW-1:0]                          x,
  output logic                                   busy,
  output logic [$clog2(XW)+fcm_pkg::FRAC_BITS-1:0] result
);
  import fcm_pkg::*;

  localparam int PW = $clog2(XW);

  lg_state_t          state, state_next;
  logic [XW-1:0]      xs;
  logic [PW-1:0]      p;
  logic [MANT_W-1:0]  m;
  logic [FRAC_BITS-1:0] frac;
  logic [3:0]         step;
  logic [2*MANT_W-1:0] sq;
  logic               norm_done;

  assign sq        = m * m;
  assign norm_done = xs[XW-1] || (p == '0);
  assign busy      = (state != LG_IDLE);
  assign result    = {p, frac};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      LG_IDLE: if (start) state_next = LG_NORM;
      LG_NORM: if (norm_done) state_next = LG_SQR;
      LG_SQR:  if (step == 4'(FRAC_BITS - 1)) state_next = LG_IDLE;
      default: state_next = LG_IDLE;
    endcase
  end

  // Datapath: shift to the leading one, then square the mantissa.
  // The result holds while idle until the next start.
  always_ff @(posedge clk) begin
    unique case (state)
      LG_IDLE: begin
        if (start) begin
          xs   <= x;
          p    <= PW'(XW - 1);
          step <= '0;
          frac <= '0;
        end
      end
      LG_NORM: begin
        if (norm_done) begin
          m <= xs[XW-1 -: MANT_W];
        end else begin
          xs <= {xs[XW-2:0], 1'b0};
          p  <= p - 1'b1;
        end
      end
      LG_SQR: begin
        step <= step + 1'b1;
        if (sq[2*MANT_W-1]) begin
          m    <= sq[2*MANT_W-1:MANT_W];
          frac <= {frac[FRAC_BITS-2:0], 1'b1};
        end else begin
          m    <= sq[2*MANT_W-2:MANT_W-1];
          frac <= {frac[FRAC_BITS-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/finite_context_model_entropy_top.sv
// ---------------------------------------------------------------------------
// finite_context_model_entropy_top
// Order-k finite-context model with additive smoothing and bit scoring.
// ---------------------------------------------------------------------------
// After reset the block sweeps both count memories to zero, one entry per
// cycle over all ALPHABET**(ORDER+1) pair entries (19683 at the defaults), and holds busy
// high meanwhile; configuration writes are taken at any time. A symbol is
// accepted when start is high and busy is low, and its result appears on
// done for one cycle; the receiver cannot stall it. A symbol that is trained
// takes one memory read and one write-back; one that follows an incomplete
// context takes only the read. A scored symbol takes the read, then the two
// log2 units side by side (a one-bit-per-cycle leading-one search over the
// LOG_W-bit operand, then ten squaring steps), then a final update.
`timescale 1ns / 1ps

`include "finite_context_model_entropy_top_macros.svh"

module finite_context_model_entropy_top #(
  parameter int ORDER      = fcm_pkg::ORDER_DEF,
  parameter int ALPHABET   = fcm_pkg::ALPHABET_DEF,
  parameter int COUNT_BITS = fcm_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [fcm_pkg::SYM_BITS-1:0]      symbol,
  input  logic                              start_req,
  output logic                              done,
  output logic [fcm_pkg::INFO_W-1:0]        symbol_bits,
  output logic [fcm_pkg::SUM_W-1:0]         total_bits,
  output logic [fcm_pkg::SCORE_W-1:0]       symbols_scored,
  output logic                              context_ready,
  input  logic                              cfg_we,
  input  logic [fcm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fcm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fcm_pkg::*;

  localparam int CTX_SPACE  = ALPHABET ** ORDER;
  localparam int PAIR_SPACE = CTX_SPACE * ALPHABET;
  localparam int CTX_AW     = $clog2(CTX_SPACE);
  localparam int PAIR_AW    = $clog2(PAIR_SPACE);
  localparam int TOTAL_W    = COUNT_BITS + 5;
  localparam int HIST_W     = SYM_BITS * ORDER;
  localparam int FILL_W     = $clog2(ORDER + 1);
  localparam int LOG_W      = TOTAL_W + ALPHA_FRAC + 1;
  localparam int LG_W       = $clog2(LOG_W) + FRAC_BITS;

  fcm_state_t state, state_next;

  // Configuration registers.
  logic               update_mode;
  logic [ALPHA_W-1:0] smoothing_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      update_mode     <= 1'b0;
      smoothing_alpha <= ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UPDATE_MODE: update_mode     <= cfg_data[0];
        REG_ALPHA:       smoothing_alpha <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequence state.
  logic [HIST_W-1:0]   history;
  logic [FILL_W-1:0]   fill;
  logic [SUM_W-1:0]    bit_sum;
  logic [SCORE_W-1:0]  scored_count;
  logic [PAIR_AW-1:0]  clr_cnt;
  logic [PAIR_AW-1:0]  pair_addr_q;
  logic [CTX_AW-1:0]   ctx_addr_q;
  logic                ready_q;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // Clamp the incoming symbol and form the effective context.
  logic [SYM_BITS-1:0] sym_c;
  logic [HIST_W-1:0]   hist_eff;
  logic [FILL_W-1:0]   fill_eff;
  logic [CTX_AW-1:0]   ctx_idx;
  logic [PAIR_AW-1:0]  pair_idx;

  always_comb begin
    sym_c = ({1'b0, symbol} >= (SYM_BITS+1)'(ALPHABET)) ? SYM_BITS'(ALPHABET - 1) : symbol;
    hist_eff = start_req ? '0 : history;
    fill_eff = start_req ? '0 : fill;
    ctx_idx  = '0;
    for (int i = ORDER - 1; i >= 0; i--) begin
      ctx_idx = CTX_AW'(ctx_idx * ALPHABET) + CTX_AW'(hist_eff[SYM_BITS*i +: SYM_BITS]);
    end
    pair_idx = PAIR_AW'(ctx_idx * ALPHABET) + PAIR_AW'(sym_c);
  end

  // Count memories.
  logic                 pair_we, tot_we;
  logic [PAIR_AW-1:0]   pair_waddr;
  logic [CTX_AW-1:0]    tot_waddr;
  logic [COUNT_BITS-1:0] pair_wdata, pair_rdata;
  logic [TOTAL_W-1:0]   tot_wdata, tot_rdata;

  fcm_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAIR_SPACE)) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .raddr (pair_idx),
    .rdata (pair_rdata)
  );

  fcm_ram #(.WIDTH(TOTAL_W), .DEPTH(CTX_SPACE)) u_total_ram (
    .clk   (clk),
    .we    (tot_we),
    .waddr (tot_waddr),
    .wdata (tot_wdata),
    .raddr (ctx_idx),
    .rdata (tot_rdata)
  );

  // Write-back: clearing sweep or training increment.
  logic train_hit;
  assign train_hit = (state == ST_READ) && ready_q && !update_mode && (pair_rdata != '1);

  always_comb begin
    if (state == ST_CLEAR) begin
      pair_we    = 1'b1;
      pair_waddr = clr_cnt;
      pair_wdata = '0;
      tot_we     = (clr_cnt < PAIR_AW'(CTX_SPACE));
      tot_waddr  = clr_cnt[CTX_AW-1:0];
      tot_wdata  = '0;
    end else begin
      pair_we    = train_hit;
      pair_waddr = pair_addr_q;
      pair_wdata = pair_rdata + 1'b1;
      tot_we     = train_hit && (tot_rdata != '1);
      tot_waddr  = ctx_addr_q;
      tot_wdata  = tot_rdata + 1'b1;
    end
  end

  // Log2 operands for scoring.
  logic [ALPHA_W-1:0] alpha_eff;
  logic [LOG_W-1:0]   num, den;
  logic               lg_start;
  logic               lg_busy_n, lg_busy_d;
  logic [LG_W-1:0]    ln, ld;

  always_comb begin
    alpha_eff = (smoothing_alpha == '0) ? ALPHA_W'(1) : smoothing_alpha;
    num = LOG_W'({pair_rdata, {ALPHA_FRAC{1'b0}}}) + LOG_W'(alpha_eff);
    den = LOG_W'({tot_rdata, {ALPHA_FRAC{1'b0}}}) + LOG_W'(alpha_eff) * LOG_W'(ALPHABET);
  end

  assign lg_start = (state == ST_READ) && ready_q && update_mode;

  fcm_log2 #(.XW(LOG_W)) u_log_num (
    .clk    (clk),
    .rst    (rst),
    .start  (lg_start),
    .x      (num),
    .busy   (lg_busy_n),
    .result (ln)
  );

  fcm_log2 #(.XW(LOG_W)) u_log_den (
    .clk    (clk),
    .rst    (rst),
    .start  (lg_start),
    .x      (den),
    .busy   (lg_busy_d),
    .result (ld)
  );

  // Information of the symbol, floored at zero and saturated.
  logic [31:0]        info32;
  logic [INFO_W-1:0]  info;
  always_comb begin
    info32 = (ld > ln) ? 32'(ld - ln) : 32'd0;
    info   = (info32 > 32'(2**INFO_W - 1)) ? '1 : info32[INFO_W-1:0];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == PAIR_AW'(PAIR_SPACE - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_READ;
      ST_READ:  state_next = (ready_q && update_mode) ? ST_LOG : ST_IDLE;
      ST_LOG:   if (!lg_busy_n && !lg_busy_d) state_next = ST_FIN;
      ST_FIN:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control and sequence registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      history      <= '0;
      fill         <= '0;
      bit_sum      <= '0;
      scored_count <= '0;
      done         <= 1'b0;
      ready_q      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        ST_IDLE: begin
          if (accept) begin
            ready_q     <= (fill_eff == FILL_W'(ORDER));
            pair_addr_q <= pair_idx;
            ctx_addr_q  <= ctx_idx;
            if (HIST_W > SYM_BITS) begin
              history <= HIST_W'({hist_eff, sym_c});
            end else begin
              history <= HIST_W'(sym_c);
            end
            if (fill_eff != FILL_W'(ORDER)) fill <= fill_eff + 1'b1;
            if (start_req) begin
              bit_sum      <= '0;
              scored_count <= '0;
            end
          end
        end
        ST_READ: begin
          if (ready_q && scored_count != '1) scored_count <= scored_count + 1'b1;
          if (!(ready_q && update_mode)) begin
            done          <= 1'b1;
            symbol_bits   <= '0;
            context_ready <= ready_q;
          end
        end
        ST_FIN: begin
          bit_sum <= (SUM_W'(info) > ('1 - bit_sum)) ? '1 : bit_sum + SUM_W'(info);
          done          <= 1'b1;
          symbol_bits   <= info;
          context_ready <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign total_bits     = bit_sum;
  assign symbols_scored = scored_count;

  // Checks.
  `FCM_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result word without a busy cycle")
  `FCM_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not raise busy")
  `FCM_ASSERT_NEXT(a_single_done, done, !done, "result word strobed twice")
  `FCM_ASSERT_NOW(a_unscored_zero, done && !context_ready, symbol_bits == '0, "bits without context")

endmodule

>>> tb/finite_context_model_entropy_top_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the finite-context model entropy block
// Feeds symbol words through the start/busy handshake and checks every done
// word against a behavioral model of counting, smoothing and log2 scoring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module finite_context_model_entropy_top_tb;
  import fcm_pkg::*;

  localparam int NSYM       = 27;
  localparam int NCTX       = NSYM * NSYM;
  localparam int NPAIR      = NCTX * NSYM;
  localparam int DRAIN_WAIT = 64;

  typedef struct packed {
    logic [INFO_W-1:0]  bits;
    logic [SUM_W-1:0]   total;
    logic [SCORE_W-1:0] scored;
    logic               ready;
  } score_word_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] mode_data;
    logic [CFG_DATA_W-1:0] alpha_data;
    logic [SYM_BITS-1:0]   sym;
    logic                  new_seq;
    bit                    typed;
    score_word_t           want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [SYM_BITS-1:0]   symbol = '0;
  logic                  start_req = 1'b0;
  logic                  done;
  logic [INFO_W-1:0]     symbol_bits;
  logic [SUM_W-1:0]      total_bits;
  logic [SCORE_W-1:0]    symbols_scored;
  logic                  context_ready;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  finite_context_model_entropy_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .symbol(symbol),
    .start_req(start_req), .done(done), .symbol_bits(symbol_bits),
    .total_bits(total_bits), .symbols_scored(symbols_scored),
    .context_ready(context_ready), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Model state of the counting context model.
  logic                  mdl_mode;
  logic [ALPHA_W-1:0]    mdl_alpha;
  logic [SYM_BITS-1:0]   hist_new, hist_old;
  int unsigned           hist_fill;
  logic [15:0]           pair_count [NPAIR];
  logic [20:0]           ctx_total [NCTX];
  logic [SUM_W-1:0]      run_sum;
  logic [SCORE_W-1:0]    run_scored;

  score_word_t           pending_words[$];
  score_word_t           typed_words[$];
  bit                    typed_flags[$];
  int                    errors = 0;
  logic [CFG_DATA_W-1:0] cur_mode_data = '0;
  logic [CFG_DATA_W-1:0] cur_alpha_data = ALPHA_RESET;

  // Fixed-point log2 with 10 fraction bits, by repeated squaring.
  function automatic longint unsigned fx_log2(longint unsigned x);
    int                 p;
    longint unsigned    m;
    longint unsigned    frac;
    if (x == 0) return 0;
    p = 0;
    frac = 0;
    while (p < 63 && (x >> (p + 1)) != 0) p++;
    m = (p >= 15) ? (x >> (p - 15)) : (x << (15 - p));
    for (int i = 0; i < 10; i++) begin
      m = (m * m) >> 15;
      if (m >= 65536) begin
        m = m >> 1;
        frac |= 64'd512 >> i;
      end
    end
    return longint'(p) * 1024 + frac;
  endfunction

  // Advances the model by one symbol and returns the word it should produce.
  function automatic score_word_t model_symbol(logic [SYM_BITS-1:0] raw, logic new_seq);
    score_word_t     w;
    logic [4:0]      s;
    int              ctx, pair;
    longint unsigned a, num, den, ln, ld, info;
    s = (raw >= NSYM) ? 5'(NSYM - 1) : raw;
    info = 0;
    if (new_seq) begin
      hist_new = '0;
      hist_old = '0;
      hist_fill = 0;
      run_sum = '0;
      run_scored = '0;
    end
    w.ready = (hist_fill >= 2);
    if (w.ready) begin
      ctx = int'(hist_old) * NSYM + int'(hist_new);
      pair = ctx * NSYM + int'(s);
      if (!mdl_mode) begin
        if (pair_count[pair] != 16'hFFFF) begin
          pair_count[pair]++;
          if (ctx_total[ctx] != 21'h1FFFFF) ctx_total[ctx]++;
        end
      end else begin
        a = (mdl_alpha == 0) ? 1 : mdl_alpha;
        num = longint'(pair_count[pair]) * 4096 + a;
        den = longint'(ctx_total[ctx]) * 4096 + NSYM * a;
        ln = fx_log2(num);
        ld = fx_log2(den);
        info = (ld > ln) ? ld - ln : 0;
        if (info > 65535) info = 65535;
        if (64'(run_sum) + info > 64'hFF_FFFF_FFFF) run_sum = '1;
        else run_sum = run_sum + SUM_W'(info);
      end
      if (run_scored != '1) run_scored++;
    end
    hist_old = hist_new;
    hist_new = s;
    if (hist_fill < 2) hist_fill++;
    w.bits = INFO_W'(info);
    w.total = run_sum;
    w.scored = run_scored;
    return w;
  endfunction

  // Predict on every accepted word, and check every done word.
  always @(posedge clk) begin
    score_word_t got, want;
    if (!rst) begin
      if (done) begin
        got = '{symbol_bits, total_bits, symbols_scored, context_ready};
        if (pending_words.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected done word: %p", got);
        end else begin
          want = pending_words.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("word mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (start && !busy) begin
        want = model_symbol(symbol, start_req);
        if (typed_flags.size() != 0 && typed_flags.pop_front()) begin
          if (typed_words[0] !== want) begin
            errors++;
            if (errors <= 10)
              $display("typed row mismatch: table %p model %p", typed_words[0], want);
          end
          want = typed_words.pop_front();
        end
        pending_words.push_back(want);
      end
    end
  end

  // Random gap length: mostly short, occasionally long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Offers one symbol word and holds start until it is accepted.
  task automatic send_symbol(logic [SYM_BITS-1:0] s, logic new_seq, bit allow_gap);
    int gap;
    symbol <= s;
    start_req <= new_seq;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets every outstanding word come back, then waits out any trailing work.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_UPDATE_MODE) begin
      mdl_mode = val[0];
      cur_mode_data = val;
    end else begin
      mdl_alpha = val;
      cur_alpha_data = val;
    end
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] mode_val, logic [CFG_DATA_W-1:0] alpha_val);
    if (mode_val != cur_mode_data || alpha_val != cur_alpha_data) begin
      drain();
      if (mode_val != cur_mode_data) write_reg(REG_UPDATE_MODE, mode_val);
      if (alpha_val != cur_alpha_data) write_reg(REG_ALPHA, alpha_val);
    end
  endtask

  // Random symbol biased toward a few codes so that counts build up.
  function automatic logic [SYM_BITS-1:0] pick_symbol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return SYM_BITS'($urandom_range(0, 3));
    if (r < 80) return 5'd26;
    return SYM_BITS'($urandom_range(0, 31));
  endfunction

  stim_row_t rows[$];

  task automatic add_row(logic [15:0] md, logic [15:0] al, logic [4:0] s, logic ns,
                         bit typed = 0, score_word_t w = '0);
    stim_row_t r;
    r.mode_data = md;
    r.alpha_data = al;
    r.sym = s;
    r.new_seq = ns;
    r.typed = typed;
    r.want = w;
    rows.push_back(r);
  endtask

  initial begin
    logic [15:0] alpha_pick;
    mdl_mode = 1'b0;
    mdl_alpha = ALPHA_RESET;
    hist_new = '0;
    hist_old = '0;
    hist_fill = 0;
    run_sum = '0;
    run_scored = '0;
    foreach (pair_count[i]) pair_count[i] = '0;
    foreach (ctx_total[i]) ctx_total[i] = '0;

    // Directed rows: training, masking, scoring at the alpha extremes.
    add_row(16'h0000, 16'd4096, 5'd0,  1'b1, 1, '{16'd0, 40'd0, 32'd0, 1'b0});
    add_row(16'h0000, 16'd4096, 5'd26, 1'b0, 1, '{16'd0, 40'd0, 32'd0, 1'b0});
    add_row(16'h0000, 16'd4096, 5'd31, 1'b0, 1, '{16'd0, 40'd0, 32'd1, 1'b1});
    add_row(16'h0000, 16'd4096, 5'd27, 1'b0);
    add_row(16'h0000, 16'd4096, 5'd0,  1'b0);
    add_row(16'h0000, 16'd4096, 5'd1,  1'b0);
    add_row(16'h0000, 16'd4096, 5'd2,  1'b0);
    add_row(16'h0001, 16'd4096, 5'd0,  1'b1, 1, '{16'd0, 40'd0, 32'd0, 1'b0});
    add_row(16'h0001, 16'd4096, 5'd26, 1'b0, 1, '{16'd0, 40'd0, 32'd0, 1'b0});
    add_row(16'h0001, 16'd4096, 5'd26, 1'b0);
    add_row(16'h0001, 16'd4096, 5'd27, 1'b0);
    add_row(16'h0001, 16'd4096, 5'd0,  1'b0);
    add_row(16'h0001, 16'd0,    5'd5,  1'b1, 1, '{16'd0, 40'd0, 32'd0, 1'b0});
    add_row(16'h0001, 16'd0,    5'd6,  1'b0);
    add_row(16'h0001, 16'd0,    5'd7,  1'b0);
    add_row(16'hFFFF, 16'hFFFF, 5'd30, 1'b0);
    add_row(16'hFFFF, 16'hFFFF, 5'd31, 1'b0);
    add_row(16'hFFFF, 16'hFFFF, 5'd26, 1'b0);
    add_row(16'h0001, 16'd1,    5'd0,  1'b0);
    add_row(16'h0001, 16'd1,    5'd0,  1'b0);
    add_row(16'h0001, 16'd1,    5'd1,  1'b0);
    add_row(16'hFFFE, 16'd1,    5'd31, 1'b1, 1, '{16'd0, 40'd0, 32'd0, 1'b0});
    add_row(16'hFFFE, 16'd1,    5'd31, 1'b0);
    add_row(16'hFFFE, 16'd1,    5'd31, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      set_config(rows[i].mode_data, rows[i].alpha_data);
      typed_flags.push_back(rows[i].typed);
      if (rows[i].typed) typed_words.push_back(rows[i].want);
      send_symbol(rows[i].sym, rows[i].new_seq, 1);
    end
    drain();
    typed_flags.delete();

    // Random phases alternating training and scoring over several alphas.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: alpha_pick = 16'd4096;
        1: alpha_pick = 16'd1;
        2: alpha_pick = 16'hFFFF;
        default: alpha_pick = 16'($urandom_range(0, 65535));
      endcase
      set_config(16'(ph % 2), alpha_pick);
      for (int n = 0; n < 125; n++)
        send_symbol(pick_symbol(), ($urandom_range(0, 99) < 3), (ph != 4));
    end

    drain();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #8000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
